/* hw/rtl/mpf_pkg.sv */
// Shared types and codes for the multilevel priority FIFO.
package mpf_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned ITEM_FIELD_W  = 16;
  localparam int unsigned PRIO_FIELD_W  = 4;
  localparam int unsigned COUNT_FIELD_W = 7;

  // Request opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } mpf_status_t;

  // Request payload
  typedef struct packed {
    logic                      op;
    logic [ITEM_FIELD_W-1:0]   item;
    logic [PRIO_FIELD_W-1:0]   priority_req;
  } mpf_in_t;

  // Result payload
  typedef struct packed {
    logic [ITEM_FIELD_W-1:0]   item_out;
    logic [ITEM_FIELD_W-1:0]   head_item;
    logic                      head_valid;
    logic [COUNT_FIELD_W-1:0]  total_count;
    logic [1:0]                status;
  } mpf_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;   // capture the request on an input transfer
    logic do_op;      // execute enqueue/dequeue, issue dequeue read
    logic do_peek;    // capture dequeued data, issue head read
    logic load_out;   // load the result register
  } mpf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
  } mpf_stat_t;

endpackage

/* hw/rtl/mpf_ctrl.sv */
// Request sequencer for the multilevel priority FIFO.
module mpf_ctrl
  import mpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mpf_stat_t stat,
  output mpf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_PEEK,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_OP;
      S_OP:   state_nxt = S_PEEK;
      S_PEEK: state_nxt = S_DONE;
      S_DONE: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command decode
  assign in_ready     = (state_r == S_IDLE);
  assign cmd.load_req = (state_r == S_IDLE) && in_valid;
  assign cmd.do_op    = (state_r == S_OP);
  assign cmd.do_peek  = (state_r == S_PEEK);
  assign cmd.load_out = (state_r == S_DONE) && stat.out_free;

endmodule

/* hw/rtl/mpf_dp.sv */
// Datapath: per-level pointers and counts, item memory, result register.
module mpf_dp
  import mpf_pkg::*;
#(
  parameter int unsigned LEVELS      = 4,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned ITEM_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mpf_cmd_t  cmd,
  output mpf_stat_t stat,
  input  mpf_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mpf_out_t  out_data
);

  localparam int unsigned SW    = (ITEM_WIDTH < ITEM_FIELD_W) ? ITEM_WIDTH : ITEM_FIELD_W;
  localparam int unsigned MDEP  = LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW    = $clog2(MDEP);
  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned PW    = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned TW    = $clog2(MDEP + 1);

  // Captured request
  mpf_in_t req_r;

  // Per-level state
  logic [PW-1:0] head_r [LEVELS];
  logic [PW-1:0] tail_r [LEVELS];
  logic [CW-1:0] cnt_r  [LEVELS];
  logic [TW-1:0] total_r;

  // Item memory and read data
  logic [SW-1:0] mem [MDEP];
  logic [SW-1:0] rd_data_r;

  // Per-request results
  logic [1:0]    status_r;
  logic [SW-1:0] taken_r;

  // Result register
  mpf_out_t out_r;
  logic     out_valid_r;

  // Lowest-numbered non-empty level
  logic [LW-1:0] busy_lv;
  logic          busy_any;

  always_comb begin
    busy_lv  = '0;
    busy_any = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        busy_lv  = LW'(i);
        busy_any = 1'b1;
      end
    end
  end

  // Request decode
  logic          is_deq;
  logic          prio_bad;
  logic [LW-1:0] prio_lv;
  logic          lvl_full;
  logic          enq_ok;
  logic          deq_ok;

  assign is_deq   = (req_r.op == OP_DEQ);
  assign prio_bad = ({1'b0, req_r.priority_req} >= (PRIO_FIELD_W + 1)'(LEVELS));
  assign prio_lv  = req_r.priority_req[LW-1:0];
  assign lvl_full = (cnt_r[prio_lv] >= CW'(LEVEL_DEPTH));
  assign enq_ok   = !is_deq && !prio_bad && !lvl_full;
  assign deq_ok   = is_deq && busy_any;

  // Memory addresses: level base plus pointer
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic          wr_en;

  assign rd_addr = AW'(busy_lv) * AW'(LEVEL_DEPTH) + AW'(head_r[busy_lv]);
  assign wr_addr = AW'(prio_lv) * AW'(LEVEL_DEPTH) + AW'(tail_r[prio_lv]);
  assign rd_en   = (cmd.do_op && deq_ok) || cmd.do_peek;
  assign wr_en   = cmd.do_op && enq_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req_r.item[SW-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Pointer increment with wrap
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(LEVEL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  // Request capture and status
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.do_op) begin
      priority if (is_deq && !busy_any) begin
        status_r <= ST_EMPTY;
      end else if (!is_deq && prio_bad) begin
        status_r <= ST_RANGE;
      end else if (!is_deq && lvl_full) begin
        status_r <= ST_FULL;
      end else begin
        status_r <= ST_OK;
      end
    end
    if (cmd.do_peek) begin
      taken_r <= (is_deq && (status_r == ST_OK)) ? rd_data_r : '0;
    end
  end

  // Level pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      total_r <= '0;
    end else if (cmd.do_op) begin
      if (enq_ok) begin
        tail_r[prio_lv] <= ptr_inc(tail_r[prio_lv]);
        cnt_r[prio_lv]  <= cnt_r[prio_lv] + CW'(1);
        total_r         <= total_r + TW'(1);
      end else if (deq_ok) begin
        head_r[busy_lv] <= ptr_inc(head_r[busy_lv]);
        cnt_r[busy_lv]  <= cnt_r[busy_lv] - CW'(1);
        total_r         <= total_r - TW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.item_out    <= ITEM_FIELD_W'(taken_r);
      out_r.head_item   <= busy_any ? ITEM_FIELD_W'(rd_data_r) : '0;
      out_r.head_valid  <= busy_any;
      out_r.total_count <= COUNT_FIELD_W'(total_r);
      out_r.status      <= status_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

/* hw/rtl/multilevel_priority_fifo_core.sv */
// For each input transfer the sequencer steps through the level update (with the
//   dequeue read), the head read and the result load, and takes no new request
//   until it is back in idle.
// A new request is taken while a result waits on out_ready; its own result then
//   holds in the sequencer until the result register frees.
// Reset (rst_n low, synchronous) empties every level and clears the control
//   state; the item memory is not cleared, and only queued entries reach the result.
module multilevel_priority_fifo_core
  import mpf_pkg::*;
#(
  parameter int unsigned LEVELS      = 4,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned ITEM_WIDTH  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mpf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mpf_out_t out_data
);

  mpf_cmd_t  cmd;
  mpf_stat_t stat;

  // Sequencer
  mpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queue state and memory
  mpf_dp #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ITEM_WIDTH  (ITEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the multilevel priority FIFO core.
module testbench
  import mpf_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_LEVELS  = 4;
  localparam int unsigned LEVEL_SLOTS = 16;
  localparam int unsigned HANDLE_W    = 16;

  localparam int RANDOM_REQS    = 900;
  localparam int HOLD_AT_RESULT = 420;   // result count that starts the long hold
  localparam int LONG_HOLD      = 300;   // cycles the receiver holds off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES  = 16;

  typedef struct {
    mpf_in_t req;
    int      gap;    // cycles to wait before offering
    bit      drain;  // hold off until every result has come back
  } pending_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mpf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mpf_out_t out_data;

  pending_req_t req_q[$];
  mpf_out_t     result_q[$];

  int n_sent = 0;      // input transfers, driver side
  int n_done = 0;      // output transfers, updated with NBA for the driver
  int done_cnt = 0;    // output transfers, monitor side
  int wait_cnt = 0;
  int stall_left = 0;
  int hold_left = 0;
  int idle_run = 0;
  int errors = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  int peak_count = 0;

  // Shadow state of the priority queue
  logic [HANDLE_W-1:0] slot_mem [NUM_LEVELS][LEVEL_SLOTS];
  int lvl_rd   [NUM_LEVELS] = '{default: 0};
  int lvl_wr   [NUM_LEVELS] = '{default: 0};
  int lvl_fill [NUM_LEVELS] = '{default: 0};
  int held_total = 0;

  multilevel_priority_fifo_core #(
    .LEVELS      (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_SLOTS),
    .ITEM_WIDTH  (HANDLE_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lowest-numbered level holding an item, NUM_LEVELS when all are empty
  function automatic int first_busy_lvl();
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      if (lvl_fill[lv] != 0) return lv;
    end
    return NUM_LEVELS;
  endfunction

  // Apply one request to the shadow queue and return the result it should give
  function automatic mpf_out_t predict_result(input mpf_in_t req);
    mpf_out_t res;
    int lv;
    res = '0;
    res.status = ST_OK;
    if (req.op == OP_ENQ) begin
      lv = int'(req.priority_req);
      if (lv >= NUM_LEVELS) begin
        res.status = ST_RANGE;
      end else if (lvl_fill[lv] >= LEVEL_SLOTS) begin
        res.status = ST_FULL;
      end else begin
        slot_mem[lv][lvl_wr[lv]] = req.item;
        lvl_wr[lv] = (lvl_wr[lv] + 1) % LEVEL_SLOTS;
        lvl_fill[lv]++;
        held_total++;
      end
    end else begin
      lv = first_busy_lvl();
      if (lv == NUM_LEVELS) begin
        res.status = ST_EMPTY;
      end else begin
        res.item_out = slot_mem[lv][lvl_rd[lv]];
        lvl_rd[lv] = (lvl_rd[lv] + 1) % LEVEL_SLOTS;
        lvl_fill[lv]--;
        held_total--;
      end
    end
    // peek after the update
    lv = first_busy_lvl();
    if (lv < NUM_LEVELS) begin
      res.head_item  = slot_mem[lv][lvl_rd[lv]];
      res.head_valid = 1'b1;
    end
    res.total_count = COUNT_FIELD_W'(held_total);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic queue_req(input logic op, input logic [15:0] itm, input logic [3:0] prio,
                           input int gap, input bit drain);
    pending_req_t p;
    p.req.op           = op;
    p.req.item         = itm;
    p.req.priority_req = prio;
    p.gap              = gap;
    p.drain            = drain;
    req_q.push_back(p);
  endtask

  // Driver: offers pending requests, honoring per-item gaps and drain points
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      wait_cnt = 0;
    end else begin
      if (in_valid && in_ready) n_sent++;
      if (!in_valid || in_ready) begin
        if (req_q.size() != 0 && wait_cnt >= req_q[0].gap &&
            (!req_q[0].drain || n_sent == n_done)) begin
          in_valid <= 1'b1;
          in_data  <= req_q[0].req;
          void'(req_q.pop_front());
          wait_cnt = 0;
        end else begin
          in_valid <= 1'b0;
          wait_cnt++;
        end
      end
    end
  end

  // Monitor: predicts on input transfers, checks output transfers, paces out_ready
  always @(posedge clk) begin
    mpf_out_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exp_res = predict_result(in_data);
        result_q.push_back(exp_res);
        status_hits[exp_res.status]++;
        if (held_total > peak_count) peak_count = held_total;
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          exp_res = result_q.pop_front();
          check_field("item_out", exp_res.item_out, out_data.item_out);
          check_field("head_item", exp_res.head_item, out_data.head_item);
          check_field("head_valid", 16'(exp_res.head_valid), 16'(out_data.head_valid));
          check_field("total_count", 16'(exp_res.total_count), 16'(out_data.total_count));
          check_field("status", 16'(exp_res.status), 16'(out_data.status));
        end
        done_cnt++;
        n_done <= done_cnt;
        if (done_cnt == HOLD_AT_RESULT) hold_left = LONG_HOLD;
        // every third stretch of results runs without stalls
        stall_left = ((done_cnt / 70) % 3 == 2) ? 0 : $urandom_range(0, 14);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** multilevel_priority_fifo_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int total_reqs;
    int enq_pct;
    int gap;
    logic op;
    logic [3:0] prio;

    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      for (int s = 0; s < LEVEL_SLOTS; s++) slot_mem[lv][s] = '0;
    end

    // Directed: empty dequeue, out-of-range levels, one level filled past full,
    // extreme handles, and service order across levels
    queue_req(OP_DEQ, 16'hFFFF, 4'hF, $urandom_range(0, 14), 1'b0);
    queue_req(OP_ENQ, 16'h1234, 4'hF, $urandom_range(0, 14), 1'b0);
    queue_req(OP_ENQ, 16'hEDCB, 4'(NUM_LEVELS), $urandom_range(0, 14), 1'b0);
    for (int k = 0; k < LEVEL_SLOTS; k++) begin
      queue_req(OP_ENQ, (k == LEVEL_SLOTS - 1) ? 16'hFFFF : 16'(16'h3000 + k),
                4'(NUM_LEVELS - 1), $urandom_range(0, 3), 1'b0);
    end
    queue_req(OP_ENQ, 16'hBEEF, 4'(NUM_LEVELS - 1), $urandom_range(0, 14), 1'b0);
    queue_req(OP_ENQ, 16'hFFFF, 4'd0, $urandom_range(0, 14), 1'b0);
    queue_req(OP_ENQ, 16'h0000, 4'd1, $urandom_range(0, 14), 1'b0);
    queue_req(OP_DEQ, 16'h0000, 4'd0, $urandom_range(0, 14), 1'b0);
    queue_req(OP_DEQ, 16'h5A5A, 4'd9, $urandom_range(0, 14), 1'b0);
    queue_req(OP_DEQ, 16'hA5A5, 4'd2, $urandom_range(0, 14), 1'b0);

    // Random: phases lean to filling, mixing or draining the levels
    for (int i = 0; i < RANDOM_REQS; i++) begin
      unique case ((i / 100) % 3)
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      op   = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
      prio = ($urandom_range(1, 10) == 1) ? 4'($urandom_range(NUM_LEVELS, 15))
                                          : 4'($urandom_range(0, NUM_LEVELS - 1));
      // back-to-back bursts, including around the long receiver hold
      if ((i / 60) % 4 == 1 || (i >= 360 && i < 480)) gap = 0;
      else gap = $urandom_range(0, 14);
      queue_req(op, 16'($urandom), prio, gap, (i == 600 || i == 800));
    end
    total_reqs = req_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid || n_done != total_reqs) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      errors++;
    end

    $display("covered %0d requests: %0d accepted, %0d empty dequeues, %0d full, %0d out of range",
             n_sent, status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
             status_hits[ST_RANGE]);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_count,
             NUM_LEVELS * LEVEL_SLOTS, errors);
    if (errors == 0) begin
      $display("** multilevel_priority_fifo_core: PASSED **");
    end else begin
      $display("** multilevel_priority_fifo_core: FAILED **");
    end
    $finish;
  end

endmodule
